@@ rtl/core/sttfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sttfd_pkg
// Shared types and constants for the serial topic frame deframer.
// ----------------------------------------------------------------------------
package sttfd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 15;
  localparam int TOPIC_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [BYTE_W-1:0] CHECK_TARGET = 8'hFF;

  localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'd255;
  localparam logic [BYTE_W-1:0] VER1_RESET  = 8'd255;
  localparam logic [BYTE_W-1:0] VER2_RESET  = 8'd254;
  localparam logic [LEN_W-1:0]  MAXLEN_RESET = 15'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC    = 2'd0,
    REG_VER_ONE = 2'd1,
    REG_VER_TWO = 2'd2,
    REG_MAX_LEN = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_BAD_VER = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_VERSION  = 4'd1,
    PH_LEN_LO   = 4'd2,
    PH_LEN_HI   = 4'd3,
    PH_LEN_CK   = 4'd4,
    PH_TOPIC_LO = 4'd5,
    PH_TOPIC_HI = 4'd6,
    PH_PAYLOAD  = 4'd7,
    PH_PAY_CK   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] version_one_byte;
    logic [BYTE_W-1:0] version_two_byte;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [TOPIC_W-1:0] frame_topic;
    logic [LEN_W-1:0]   payload_length;
    logic [LEN_W-1:0]   byte_index;
    logic               version_is_two;
    logic               length_check_ok;
    logic               payload_check_ok;
    logic               last;
  } result_t;

endpackage

@@ rtl/core/sttfd_cfg.sv @@
// ----------------------------------------------------------------------------
// sttfd_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module sttfd_cfg
  import sttfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte        <= SYNC_RESET;
      cfg.version_one_byte <= VER1_RESET;
      cfg.version_two_byte <= VER2_RESET;
      cfg.max_length       <= MAXLEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SYNC:    cfg.sync_byte        <= cfg_data[BYTE_W-1:0];
        REG_VER_ONE: cfg.version_one_byte <= cfg_data[BYTE_W-1:0];
        REG_VER_TWO: cfg.version_two_byte <= cfg_data[BYTE_W-1:0];
        REG_MAX_LEN: cfg.max_length       <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/sttfd_parse.sv @@
// ----------------------------------------------------------------------------
// sttfd_parse
// Frame parser: phase state machine, field capture and checksum sums.
// Updates on step and offers at most one result for the byte in hand.
// ----------------------------------------------------------------------------
module sttfd_parse
  import sttfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              res_valid,
  output result_t           res
);

  phase_t              phase, phase_next;
  logic                version_flag, version_flag_next;
  logic [BYTE_W-1:0]   length_low, length_low_next;
  logic [LEN_W-1:0]    frame_length, frame_length_next;
  logic                length_sum_ok, length_sum_ok_next;
  logic [TOPIC_W-1:0]  topic_value, topic_value_next;
  logic [LEN_W-1:0]    payload_count, payload_count_next;
  logic [BYTE_W-1:0]   running_sum, running_sum_next;

  logic [TOPIC_W-1:0]  raw_len;
  logic                len_bad;
  logic [BYTE_W-1:0]   sum_with_byte;
  logic [LEN_W-1:0]    count_inc;

  assign raw_len       = {byte_in, length_low};
  assign len_bad       = raw_len[TOPIC_W-1] || (raw_len == '0) ||
                         (raw_len[LEN_W-1:0] > cfg.max_length);
  assign sum_with_byte = running_sum + byte_in;
  assign count_inc     = payload_count + LEN_W'(1);

  always_comb begin
    phase_next         = phase;
    version_flag_next  = version_flag;
    length_low_next    = length_low;
    frame_length_next  = frame_length;
    length_sum_ok_next = length_sum_ok;
    topic_value_next   = topic_value;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    unique case (phase)
      PH_VERSION: begin
        if (byte_in == cfg.version_one_byte) begin
          version_flag_next = 1'b0;
          phase_next        = PH_LEN_LO;
        end else if (byte_in == cfg.version_two_byte) begin
          version_flag_next = 1'b1;
          phase_next        = PH_LEN_LO;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_low_next = byte_in;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = raw_len[LEN_W-1:0];
        running_sum_next  = length_low + byte_in;
        phase_next        = len_bad ? PH_HUNT : PH_LEN_CK;
      end
      PH_LEN_CK: begin
        length_sum_ok_next = (sum_with_byte == CHECK_TARGET);
        phase_next         = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        topic_value_next = {8'd0, byte_in};
        running_sum_next = byte_in;
        phase_next       = PH_TOPIC_HI;
      end
      PH_TOPIC_HI: begin
        topic_value_next   = {byte_in, topic_value[BYTE_W-1:0]};
        running_sum_next   = sum_with_byte;
        payload_count_next = '0;
        phase_next         = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next   = sum_with_byte;
        payload_count_next = count_inc;
        if (count_inc >= frame_length) phase_next = PH_PAY_CK;
      end
      PH_PAY_CK: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (byte_in == cfg.sync_byte) ? PH_VERSION : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.kind  = KIND_PAYLOAD;
    unique case (phase)
      PH_VERSION: begin
        if (byte_in != cfg.version_one_byte && byte_in != cfg.version_two_byte) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_VER;
          res.last  = 1'b1;
        end
      end
      PH_LEN_HI: begin
        if (len_bad) begin
          res_valid          = 1'b1;
          res.kind           = KIND_BAD_LEN;
          res.payload_length = raw_len[LEN_W-1:0];
          res.version_is_two = version_flag;
          res.last           = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid           = 1'b1;
        res.kind            = KIND_PAYLOAD;
        res.data_byte       = byte_in;
        res.frame_topic     = topic_value;
        res.payload_length  = frame_length;
        res.byte_index      = payload_count;
        res.version_is_two  = version_flag;
        res.length_check_ok = length_sum_ok;
      end
      PH_PAY_CK: begin
        res_valid            = 1'b1;
        res.kind             = KIND_END;
        res.frame_topic      = topic_value;
        res.payload_length   = frame_length;
        res.version_is_two   = version_flag;
        res.length_check_ok  = length_sum_ok;
        res.payload_check_ok = (sum_with_byte == CHECK_TARGET);
        res.last             = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      version_flag  <= 1'b0;
      length_low    <= '0;
      frame_length  <= '0;
      length_sum_ok <= 1'b0;
      topic_value   <= '0;
      payload_count <= '0;
      running_sum   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      version_flag  <= version_flag_next;
      length_low    <= length_low_next;
      frame_length  <= frame_length_next;
      length_sum_ok <= length_sum_ok_next;
      topic_value   <= topic_value_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

@@ rtl/core/sttfd_out.sv @@
// ----------------------------------------------------------------------------
// sttfd_out
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module sttfd_out
  import sttfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    space,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

@@ rtl/core/serial_topic_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// serial_topic_frame_deframer
// Hunts for sync, checks version and length, streams payload bytes tagged
// with topic and index, and ends each frame with a checksum or error beat.
//
//   channel  direction  handshake              payload
//   rx       in         in_valid / in_ready    rx_byte
//   result   out        out_valid / out_ready  kind .. last (9 fields)
//   cfg      in         cfg_wr_en              cfg_index, cfg_data
//
// One byte per cycle while out_ready takes results: input register, one parse
// step, result register. A byte's result is loaded when its parse step runs.
// Synchronous reset returns to hunting with the register reset values.
// A stalled result holds the parse step; the input register still takes a beat
// if it is empty, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module serial_topic_frame_deframer
  import sttfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [BYTE_W-1:0]     data_byte,
  output logic [TOPIC_W-1:0]    frame_topic,
  output logic [LEN_W-1:0]      payload_length,
  output logic [LEN_W-1:0]      byte_index,
  output logic                  version_is_two,
  output logic                  length_check_ok,
  output logic                  payload_check_ok,
  output logic                  last,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;
  logic              space;
  logic              step;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  assign step     = in_vld && space;
  assign in_ready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  sttfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sttfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .byte_in   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sttfd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .space     (space),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind             = out_res.kind;
  assign data_byte        = out_res.data_byte;
  assign frame_topic      = out_res.frame_topic;
  assign payload_length   = out_res.payload_length;
  assign byte_index       = out_res.byte_index;
  assign version_is_two   = out_res.version_is_two;
  assign length_check_ok  = out_res.length_check_ok;
  assign payload_check_ok = out_res.payload_check_ok;
  assign last             = out_res.last;

endmodule
